// File: rtl/rtb_pkg.sv
// Types and constants shared by the repeating timer bank.
`timescale 1ns / 1ps
package rtb_pkg;

  localparam logic [1:0] K_START = 2'd0;
  localparam logic [1:0] K_FORCE = 2'd1;
  localparam logic [1:0] K_STOP  = 2'd2;
  localparam logic [1:0] K_POLL  = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_EXP  = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  localparam logic [15:0] FOREVER = 16'hFFFF;
  localparam int unsigned MAX_SCAN = 16;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         channel;
    logic [31:0]        period;
    logic signed [15:0] repeat_count;
    logic [31:0]        now_tick;
  } in_item_t;

  typedef struct packed {
    logic [3:0] out_channel;
    logic [1:0] status;
    logic       ended;
    logic [4:0] active_count;
    logic       last;
  } out_item_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic        arm;
    logic        clr;
    logic [31:0] period;
    logic [15:0] count;
    logic [31:0] now_tick;
  } cmd_t;

  // Status that one cell shows to the controller and its neighbour
  typedef struct packed {
    logic armed;
    logic hit;
    logic ended;
    logic tok;
  } cell_sts_t;

endpackage

// File: rtl/rtb_cell.sv
// One timer channel: period, deadline, repeat count and the scan token.
`timescale 1ns / 1ps
module rtb_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          sel,
  input  rtb_pkg::cmd_t cmd,
  input  logic          tok_in,
  input  logic          advance,
  output rtb_pkg::cell_sts_t sts
);
  import rtb_pkg::*;

  logic        armed_r;
  logic        tok_r;
  logic [15:0] rem_r;
  logic [31:0] per_r;
  logic [31:0] dl_r;
  logic [15:0] rem_dec;
  logic        hit;
  logic        ended;

  assign hit     = tok_r & armed_r & (dl_r <= cmd.now_tick);
  assign rem_dec = (rem_r == FOREVER) ? rem_r : rem_r - 16'd1;
  assign ended   = hit & (rem_dec == 16'd0);

  assign sts.armed = armed_r;
  assign sts.hit   = hit;
  assign sts.ended = ended;
  assign sts.tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      tok_r   <= 1'b0;
      rem_r   <= '0;
      per_r   <= '0;
      dl_r    <= '0;
    end else begin
      if (advance) begin
        tok_r <= tok_in;
      end
      if (sel && cmd.arm) begin
        armed_r <= 1'b1;
        per_r   <= cmd.period;
        dl_r    <= cmd.now_tick + cmd.period;
        rem_r   <= cmd.count;
      end else if (sel && cmd.clr) begin
        armed_r <= 1'b0;
        per_r   <= '0;
        dl_r    <= '0;
        rem_r   <= '0;
      end else if (advance && hit) begin
        if (ended) begin
          // count exhausted: disarm, keep period and deadline
          armed_r <= 1'b0;
          rem_r   <= '0;
        end else begin
          rem_r <= rem_dec;
          dl_r  <= per_r + cmd.now_tick;
        end
      end
    end
  end

endmodule

// File: rtl/repeating_timer_bank_unit.sv
// Top level of the repeating timer bank: controller and the row of channel cells.
`timescale 1ns / 1ps
// Usage
//   in_valid/in_ready/in_item carry commands: start, force start, stop, poll.
//   out_valid/out_ready/out_item carry results; last marks the final result
//   of a command. Start, force start and stop give one result; a poll gives
//   one result per expiring channel in ascending order, or a single "none".
// Command flow
//   Start, force start and stop: the command waits in S_CMD until the output
//   register is free, then its result is registered and the unit returns to S_IDLE.
//   Poll: a token walks the cell row one channel per cycle unless a stall holds it;
//   the scan covers min(NUM_CHANNELS,16) channels, in ascending order.
//   One command is in progress at a time; in_ready is high only when idle.
// Reset
//   rst_n (synchronous, active low) disarms every channel, clears the
//   active count and empties the result register.
// Stall
//   A held result stays in the output register; the scan token holds at an
//   expiring channel while the pending result is full and the output beat is held.
module repeating_timer_bank_unit #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rtb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rtb_pkg::out_item_t out_item
);
  import rtb_pkg::*;

  localparam int SCAN_N = (NUM_CHANNELS < MAX_SCAN) ? NUM_CHANNELS : MAX_SCAN;

  typedef enum logic [1:0] {S_IDLE, S_CMD, S_SCAN, S_FIN} state_t;

  state_t      state_r;
  in_item_t    item_r;
  out_item_t   out_r;
  out_item_t   pend_r;
  logic        out_valid_r;
  logic        pend_v_r;
  logic [4:0]  total_r;
  logic [3:0]  idx_r;

  cell_sts_t   sts [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] sel;
  logic [NUM_CHANNELS-1:0] sel_ch;
  logic [NUM_CHANNELS-1:0] armed_vec;
  logic [NUM_CHANNELS-1:0] hit_vec;
  logic [NUM_CHANNELS-1:0] ended_vec;

  logic      in_fire;
  logic      slot_free;
  logic      out_load;
  logic      tok_start;
  logic      advance;
  logic      hit_any;
  logic      ended_any;
  logic      scan_done;
  logic      ch_ok;
  logic      armed_sel;
  logic      is_start;
  logic      is_force;
  logic      is_stop;
  logic      cnt_zero;
  logic      do_arm;
  logic      cmd_go;
  logic      inc;
  logic      dec;
  logic [4:0] cmd_total;
  cmd_t      cmd;
  out_item_t cmd_res;
  out_item_t exp_res;
  out_item_t fin_res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign slot_free = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Command decode against the addressed channel
  assign ch_ok     = ({28'd0, item_r.channel} < 32'(SCAN_N));
  assign armed_sel = |(sel_ch & armed_vec);
  assign is_start  = (item_r.kind == K_START);
  assign is_force  = (item_r.kind == K_FORCE);
  assign is_stop   = (item_r.kind == K_STOP);
  assign cnt_zero  = (item_r.repeat_count == 16'sd0);
  assign do_arm    = ch_ok & (is_force | (is_start & ~armed_sel));
  assign cmd_go    = (state_r == S_CMD) & slot_free;

  assign cmd.arm      = cmd_go & do_arm & ~cnt_zero;
  assign cmd.clr      = cmd_go & ((do_arm & cnt_zero) | (is_stop & armed_sel));
  assign cmd.period   = item_r.period;
  assign cmd.count    = item_r.repeat_count;
  assign cmd.now_tick = item_r.now_tick;

  assign sel = sel_ch & {NUM_CHANNELS{cmd_go}};
  assign inc = do_arm & ~cnt_zero & ~armed_sel;
  assign dec = (do_arm & cnt_zero & armed_sel) | (is_stop & armed_sel);
  assign cmd_total = total_r + 5'(inc) - 5'(dec);

  always_comb begin
    cmd_res              = '0;
    cmd_res.out_channel  = item_r.channel;
    cmd_res.status       = (is_stop & ~armed_sel) ? ST_FAIL : ST_DONE;
    cmd_res.active_count = cmd_total;
    cmd_res.last         = 1'b1;
  end

  // Scan control
  assign hit_any   = |hit_vec;
  assign ended_any = |ended_vec;
  assign tok_start = in_fire & (in_item.kind == K_POLL);
  assign advance   = tok_start |
                     ((state_r == S_SCAN) & (~hit_any | ~pend_v_r | slot_free));
  assign scan_done = (state_r == S_SCAN) & advance & sts[SCAN_N-1].tok;

  // A new beat enters the output register this cycle
  assign out_load  = ((state_r == S_CMD) & slot_free) |
                     ((state_r == S_SCAN) & advance & hit_any & pend_v_r) |
                     ((state_r == S_FIN) & slot_free);

  always_comb begin
    exp_res              = '0;
    exp_res.out_channel  = idx_r;
    exp_res.status       = ST_EXP;
    exp_res.ended        = ended_any;
    exp_res.active_count = ended_any ? total_r - 5'd1 : total_r;
    exp_res.last         = 1'b0;
  end

  always_comb begin
    if (pend_v_r) begin
      fin_res      = pend_r;
      fin_res.last = 1'b1;
    end else begin
      fin_res              = '0;
      fin_res.status       = ST_NONE;
      fin_res.active_count = total_r;
      fin_res.last         = 1'b1;
    end
  end

  // Row of channel cells with the token handed along
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = tok_start;
    end else if (i < SCAN_N) begin : g_mid
      assign tok_in = sts[i-1].tok;
    end else begin : g_off
      assign tok_in = 1'b0;
    end

    if (i < SCAN_N) begin : g_sel
      assign sel_ch[i] = ch_ok & (item_r.channel == 4'(i));
    end else begin : g_nosel
      assign sel_ch[i] = 1'b0;
    end

    assign armed_vec[i] = sts[i].armed;
    assign hit_vec[i]   = sts[i].hit;
    assign ended_vec[i] = sts[i].ended;

    rtb_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .sel     (sel[i]),
      .cmd     (cmd),
      .tok_in  (tok_in),
      .advance (advance),
      .sts     (sts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      total_r     <= '0;
      idx_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            item_r  <= in_item;
            idx_r   <= '0;
            state_r <= (in_item.kind == K_POLL) ? S_SCAN : S_CMD;
          end
        end
        S_CMD: begin
          if (slot_free) begin
            out_r       <= cmd_res;
            total_r     <= cmd_total;
            state_r     <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (advance) begin
            idx_r <= idx_r + 4'd1;
            if (hit_any) begin
              // push the earlier expiry out, hold this one until we know
              // whether it is the final beat
              if (pend_v_r) begin
                out_r       <= pend_r;
              end
              pend_r   <= exp_res;
              pend_v_r <= 1'b1;
              if (ended_any) begin
                total_r <= total_r - 5'd1;
              end
            end
            if (scan_done) begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_r       <= fin_res;
            pend_v_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/rtb_checker.sv
// Port-level checks for the repeating timer bank, bound to the top level.
`timescale 1ns / 1ps
module rtb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rtb_pkg::out_item_t out_item
);
  import rtb_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.active_count <= 5'd16)
    else $error("active count out of range");

  a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_NONE |->
      out_item.out_channel == 4'd0 && out_item.last && !out_item.ended)
    else $error("malformed empty poll result");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_EXP |-> out_item.last && !out_item.ended)
    else $error("command result not final or flagged ended");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new command taken while one is in progress");

endmodule

bind repeating_timer_bank_unit rtb_checker u_rtb_checker (.*);
